>>> hdl/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared types, constants and helpers for the CIGAR block splitter.
// ----------------------------------------------------------------------------
package cbs_pkg;

   localparam int POS_WIDTH  = 32;
   localparam int OP_KIND_W  = 4;
   localparam int OP_LEN_W   = 28;
   localparam int START_W    = 31;
   localparam int OUT_POS_W  = 32;

   localparam int MAX_IN_W   = (START_W > OP_LEN_W) ? START_W : OP_LEN_W;
   localparam int EXT_W      = ((POS_WIDTH > MAX_IN_W) ? POS_WIDTH : MAX_IN_W) + 1;
   localparam int WIDE_OUT_W = (POS_WIDTH > OUT_POS_W) ? POS_WIDTH : OUT_POS_W;

   localparam int REQ_FIELDS_W = OP_KIND_W + OP_LEN_W + START_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W   = 2 * OUT_POS_W;
   localparam int RSP_USER_W   = 2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [POS_WIDTH-1:0] pos_type;
   localparam pos_type POS_MAX = '1;

   localparam logic [OP_KIND_W-1:0] OP_MATCH = 4'd0;
   localparam logic [OP_KIND_W-1:0] OP_INS   = 4'd1;
   localparam logic [OP_KIND_W-1:0] OP_DEL   = 4'd2;
   localparam logic [OP_KIND_W-1:0] OP_SKIP  = 4'd3;
   localparam logic [OP_KIND_W-1:0] OP_SOFT  = 4'd4;
   localparam logic [OP_KIND_W-1:0] OP_HARD  = 4'd5;
   localparam logic [OP_KIND_W-1:0] OP_PAD   = 4'd6;

   typedef enum logic [1:0] {
      CLS_EXTEND,
      CLS_CLOSE,
      CLS_NOP,
      CLS_BAD
   } op_class_type;

   typedef struct packed {
      op_class_type          cls;
      logic [OP_LEN_W-1:0]   len;
      logic [START_W-1:0]    start;
      logic                  first;
      logic                  last;
   } op_item_type;

   typedef struct packed {
      logic [OUT_POS_W-1:0]  block_end;
      logic [OUT_POS_W-1:0]  block_begin;
      logic                  bad_op;
      logic                  block_valid;
      logic                  final_result;
   } block_rsp_type;

   function automatic pos_type sat_add(pos_type a, logic [OP_LEN_W-1:0] b);
      logic [EXT_W-1:0] s;
      pos_type          r;
      s = EXT_W'(a) + EXT_W'(b);
      if (s > EXT_W'(POS_MAX)) r = POS_MAX;
      else                     r = s[POS_WIDTH-1:0];
      return r;
   endfunction

   function automatic pos_type sat_start(logic [START_W-1:0] v);
      logic [EXT_W-1:0] e;
      pos_type          r;
      e = EXT_W'(v);
      if (e > EXT_W'(POS_MAX)) r = POS_MAX;
      else                     r = e[POS_WIDTH-1:0];
      return r;
   endfunction

   function automatic logic [OUT_POS_W-1:0] out_pos(pos_type p);
      logic [WIDE_OUT_W-1:0] w;
      w = WIDE_OUT_W'(p);
      return w[OUT_POS_W-1:0];
   endfunction

endpackage

>>> hdl/cbs_front.sv
// ----------------------------------------------------------------------------
// cbs_front
// Decodes an incoming CIGAR op into its effect on the block being built.
// ----------------------------------------------------------------------------
module cbs_front import cbs_pkg::*; (
   input  logic [OP_KIND_W-1:0] op_kind,
   input  logic [OP_LEN_W-1:0]  op_length,
   input  logic [START_W-1:0]   align_start,
   input  logic                 first_op,
   input  logic                 last_op,
   input  logic                 break_on_deletion,
   output op_item_type          item
);

   op_class_type cls;

   always_comb begin
      unique case (op_kind) inside
         OP_MATCH:                         cls = CLS_EXTEND;
         OP_DEL:                           cls = break_on_deletion ? CLS_CLOSE : CLS_EXTEND;
         OP_SKIP:                          cls = CLS_CLOSE;
         OP_INS, OP_SOFT, OP_HARD, OP_PAD: cls = CLS_NOP;
         default:                          cls = CLS_BAD;
      endcase
   end

   assign item.cls   = cls;
   assign item.len   = op_length;
   assign item.start = align_start;
   assign item.first = first_op;
   assign item.last  = last_op;

endmodule

>>> hdl/cbs_queue.sv
// ----------------------------------------------------------------------------
// cbs_queue
// Short FIFO of decoded ops between the decode and execute sides.
// ----------------------------------------------------------------------------
module cbs_queue import cbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  op_item_type push_item,
   output logic        full,
   input  logic        pop,
   output op_item_type head_item,
   output logic        not_empty
);

   op_item_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (!push && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) mem_ff[wr_ptr_ff] <= push_item;
   end

endmodule

>>> hdl/cbs_back.sv
// ----------------------------------------------------------------------------
// cbs_back
// Executes decoded ops: tracks position and open block, registers results.
// ----------------------------------------------------------------------------
module cbs_back import cbs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  op_item_type   item,
   input  logic          item_valid,
   output logic          pop,
   output block_rsp_type rsp,
   output logic          rsp_valid,
   input  logic          rsp_ready
);

   pos_type       cur_pos_ff, cur_pos_in;
   pos_type       open_start_ff, open_start_in;
   logic          any_emit_ff, any_emit_in;
   logic          err_ff, err_in;
   logic          rsp_valid_ff, rsp_valid_in;
   block_rsp_type rsp_ff, rsp_in;

   pos_type       pos0, start0, added;
   logic          any0, err0, closing, emit_close, produce;
   block_rsp_type res;

   assign pop = item_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      pos0    = item.first ? sat_start(item.start) : cur_pos_ff;
      start0  = item.first ? pos0 : open_start_ff;
      any0    = item.first ? 1'b0 : any_emit_ff;
      err0    = item.first ? 1'b0 : err_ff;
      added   = sat_add(pos0, item.len);
      closing = !err0 && (item.cls == CLS_CLOSE);
      emit_close = closing && (pos0 > start0);

      cur_pos_in    = pos0;
      open_start_in = start0;
      any_emit_in   = any0;
      err_in        = err0;
      if (!err0) begin
         case (item.cls)
            CLS_EXTEND: cur_pos_in = added;
            CLS_CLOSE: begin
               cur_pos_in    = added;
               open_start_in = added;
            end
            CLS_BAD:    err_in = 1'b1;
            default:    ;
         endcase
      end
      if (emit_close) any_emit_in = 1'b1;

      res.block_begin  = out_pos(start0);
      res.block_end    = out_pos(pos0);
      res.block_valid  = 1'b1;
      res.final_result = item.last;
      res.bad_op       = 1'b0;
      produce          = emit_close;
      if (item.last && !emit_close) begin
         produce = 1'b1;
         if (err_in || !((cur_pos_in > open_start_in) || !any_emit_in)) begin
            res.block_begin = '0;
            res.block_end   = '0;
            res.block_valid = 1'b0;
            res.bad_op      = err_in;
         end else begin
            res.block_begin = out_pos(open_start_in);
            res.block_end   = out_pos(cur_pos_in);
            any_emit_in     = 1'b1;
         end
      end

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      if (pop && produce) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_pos_ff    <= '0;
         open_start_ff <= '0;
         any_emit_ff   <= 1'b0;
         err_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (pop) begin
            cur_pos_ff    <= cur_pos_in;
            open_start_ff <= open_start_in;
            any_emit_ff   <= any_emit_in;
            err_ff        <= err_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hdl/cigar_block_splitter.sv
// ----------------------------------------------------------------------------
// cigar_block_splitter
// Splits the reference span of an alignment into blocks from its CIGAR ops.
// ----------------------------------------------------------------------------
// Takes one CIGAR op per request and sustains one request per clock while
// rsp_ keeps up. An op is decoded on acceptance, held in a two-entry queue,
// and executed by the back end (one saturating add and position compares).
// A response, when the op yields one, is registered once the back end pops
// the op from the queue. The back end executes no op while a response waits
// on rsp_, so a response stall fills the queue and req_tready drops once two
// ops are queued. Write break_on_deletion on csr_ only while no alignment is
// in flight.
// ----------------------------------------------------------------------------
module cigar_block_splitter import cbs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // op_kind[3:0], op_length[31:4], align_start[62:32], zero[63]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // first_op
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // block_begin[31:0], block_end[63:32]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // block_valid[0], bad_op[1]
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_data
);

   logic          break_del_ff;
   op_item_type   dec_item, head_item;
   logic          q_full, q_not_empty, q_pop, push;
   block_rsp_type rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         break_del_ff <= 1'b0;
      end else if (csr_valid) begin
         break_del_ff <= csr_data;
      end
   end

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

   cbs_front u_front (
      .op_kind           (req_tdata[OP_KIND_W-1:0]),
      .op_length         (req_tdata[OP_KIND_W+OP_LEN_W-1:OP_KIND_W]),
      .align_start       (req_tdata[REQ_FIELDS_W-1:OP_KIND_W+OP_LEN_W]),
      .first_op          (req_tuser),
      .last_op           (req_tlast),
      .break_on_deletion (break_del_ff),
      .item              (dec_item)
   );

   cbs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (dec_item),
      .full      (q_full),
      .pop       (q_pop),
      .head_item (head_item),
      .not_empty (q_not_empty)
   );

   cbs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (head_item),
      .item_valid (q_not_empty),
      .pop        (q_pop),
      .rsp        (rsp),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready)
   );

   assign rsp_tdata = {rsp.block_end, rsp.block_begin};
   assign rsp_tuser = {rsp.bad_op, rsp.block_valid};
   assign rsp_tlast = rsp.final_result;

endmodule

>>> hdl/cbs_checker.sv
// ----------------------------------------------------------------------------
// cbs_checker
// Port-level assertions for the CIGAR block splitter, bound to the top.
// ----------------------------------------------------------------------------
module cbs_checker import cbs_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser,
   input logic                  rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0 && rsp_tlast)
      else $error("end marker with nonzero span or not final");

   a_bad_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0] && rsp_tlast)
      else $error("bad op flagged on a block response");

   a_split_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] && !rsp_tlast
         |-> rsp_tdata[RSP_DATA_W-1:OUT_POS_W] > rsp_tdata[OUT_POS_W-1:0])
      else $error("empty intermediate block");

endmodule

bind cigar_block_splitter cbs_checker u_cbs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CIGAR block splitter.
// ----------------------------------------------------------------------------
// Streams CIGAR ops into req_, predicts the emitted reference blocks with a
// scoreboard that tracks position, open block and error state, and checks
// each rsp_ response in order. Covers the break_on_deletion settings, a
// directed set of corner cases, and random alignments under several
// idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
   import cbs_pkg::*;

   localparam logic [OP_KIND_W-1:0] OP_BAD_LOW  = 4'd7;
   localparam logic [OP_KIND_W-1:0] OP_BAD_HIGH = 4'd15;
   localparam logic [OP_LEN_W-1:0]  LEN_MAX     = '1;
   localparam logic [START_W-1:0]   START_MAX   = '1;
   localparam int PHASE_ITEMS = 400;

   typedef struct packed {
      logic [OUT_POS_W-1:0] block_begin;
      logic [OUT_POS_W-1:0] block_end;
      logic                 block_valid;
      logic                 final_result;
      logic                 bad_op;
   } block_result_type;

   class block_scoreboard;
      pos_type          cur_pos;
      pos_type          open_start;
      bit               emitted;
      bit               err_seen;
      bit               break_del;
      block_result_type expected_q[$];
      int               errors;

      function new();
         cur_pos    = '0;
         open_start = '0;
         emitted    = 1'b0;
         err_seen   = 1'b0;
         break_del  = 1'b0;
         errors     = 0;
      endfunction

      function pos_type pos_add(pos_type a, logic [OP_LEN_W-1:0] b);
         logic [POS_WIDTH:0] s;
         s = {1'b0, a} + (POS_WIDTH + 1)'(b);
         return s[POS_WIDTH] ? POS_MAX : s[POS_WIDTH-1:0];
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_op(logic [OP_KIND_W-1:0] kind, logic [OP_LEN_W-1:0] len,
                            logic [START_W-1:0] start, bit first_op, bit last_op);
         bit               closing;
         bit               have;
         block_result_type r;
         closing = 1'b0;
         have    = 1'b0;
         r       = '0;
         if (first_op) begin
            cur_pos    = pos_type'(start);
            open_start = cur_pos;
            emitted    = 1'b0;
            err_seen   = 1'b0;
         end
         if (!err_seen) begin
            case (kind)
               OP_MATCH: cur_pos = pos_add(cur_pos, len);
               OP_DEL: begin
                  if (break_del) closing = 1'b1;
                  else           cur_pos = pos_add(cur_pos, len);
               end
               OP_SKIP: closing = 1'b1;
               OP_INS, OP_SOFT, OP_HARD, OP_PAD: ;
               default: err_seen = 1'b1;
            endcase
         end
         if (closing) begin
            if (cur_pos > open_start) begin
               r = '{open_start[OUT_POS_W-1:0], cur_pos[OUT_POS_W-1:0], 1'b1, 1'b0, 1'b0};
               have    = 1'b1;
               emitted = 1'b1;
            end
            cur_pos    = pos_add(cur_pos, len);
            open_start = cur_pos;
         end
         if (last_op) begin
            if (have) begin
               r.final_result = 1'b1;
            end else if (err_seen) begin
               r    = '{'0, '0, 1'b0, 1'b1, 1'b1};
               have = 1'b1;
            end else if (cur_pos > open_start || !emitted) begin
               r = '{open_start[OUT_POS_W-1:0], cur_pos[OUT_POS_W-1:0], 1'b1, 1'b1, 1'b0};
               have    = 1'b1;
               emitted = 1'b1;
            end else begin
               r    = '{'0, '0, 1'b0, 1'b1, 1'b0};
               have = 1'b1;
            end
         end
         if (have) expected_q.insert(expected_q.size(), r);
      endfunction

      function void check_block(block_result_type got);
         block_result_type exp;
         if (expected_q.size() == 0) begin
            $error("unexpected block: begin %0d end %0d", got.block_begin, got.block_end);
            errors++;
            return;
         end
         exp = expected_q.pop_front();
         if (got.block_begin !== exp.block_begin) begin
            $error("block_begin: expected %0d, actual %0d", exp.block_begin, got.block_begin);
            errors++;
         end
         if (got.block_end !== exp.block_end) begin
            $error("block_end: expected %0d, actual %0d", exp.block_end, got.block_end);
            errors++;
         end
         if (got.block_valid !== exp.block_valid) begin
            $error("block_valid: expected %0d, actual %0d", exp.block_valid, got.block_valid);
            errors++;
         end
         if (got.final_result !== exp.final_result) begin
            $error("final_result: expected %0d, actual %0d",
                   exp.final_result, got.final_result);
            errors++;
         end
         if (got.bad_op !== exp.bad_op) begin
            $error("bad_op: expected %0d, actual %0d", exp.bad_op, got.bad_op);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic                  csr_data = 1'b0;

   int idle_pct  = 0;
   int stall_pct = 0;
   block_scoreboard sb = new();

   cigar_block_splitter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_block('{rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser[0], rsp_tlast,
                          rsp_tuser[1]});
      end
   end

   task automatic send_op(input logic [OP_KIND_W-1:0] kind, input logic [OP_LEN_W-1:0] len,
                          input logic [START_W-1:0] start, input bit first_op,
                          input bit last_op);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, start, len, kind};
      req_tuser  <= first_op;
      req_tlast  <= last_op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_op(kind, len, start, first_op, last_op);
      @(negedge clock);
   endtask

   // caller is at a falling edge with no request pending
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic write_break(input bit value);
      drain();
      repeat (8) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.break_del = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [OP_KIND_W-1:0] pick_kind();
      int r;
      r = $urandom_range(99);
      if (r < 35)      return OP_MATCH;
      else if (r < 50) return OP_DEL;
      else if (r < 65) return OP_SKIP;
      else if (r < 97) begin
         case ($urandom_range(3))
            0:       return OP_INS;
            1:       return OP_SOFT;
            2:       return OP_HARD;
            default: return OP_PAD;
         endcase
      end
      return OP_KIND_W'($urandom_range(OP_BAD_HIGH, OP_BAD_LOW));
   endfunction

   function automatic logic [OP_LEN_W-1:0] pick_len();
      case ($urandom_range(9))
         0:       return '0;
         1:       return LEN_MAX;
         2, 3:    return OP_LEN_W'($urandom);
         default: return OP_LEN_W'($urandom_range(200));
      endcase
   endfunction

   function automatic logic [START_W-1:0] pick_start();
      case ($urandom_range(9))
         0:       return '0;
         1:       return START_MAX;
         2:       return START_MAX - START_W'($urandom_range(1000));
         default: return START_W'($urandom);
      endcase
   endfunction

   task automatic random_ops(input int count);
      int  sent;
      int  n_ops;
      bit  broken;
      bit  first_op;
      bit  last_op;
      sent = 0;
      while (sent < count) begin
         n_ops  = $urandom_range(1, 8);
         broken = ($urandom_range(9) == 0);
         for (int i = 0; i < n_ops; i++) begin
            first_op = broken ? ($urandom_range(3) == 0) : (i == 0);
            last_op  = broken ? ($urandom_range(3) == 0) : (i == n_ops - 1);
            send_op(pick_kind(), pick_len(), pick_start(), first_op, last_op);
            sent++;
         end
         if (broken) send_op(OP_MATCH, pick_len(), pick_start(), 1'b0, 1'b1);
         if ($urandom_range(24) == 0) drain();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_break(1'b0);

      // no first op after reset: continue from the reset state
      send_op(OP_MATCH, 28'd5, '0, 1'b0, 1'b0);
      send_op(OP_SKIP, 28'd3, '0, 1'b0, 1'b0);
      send_op(OP_MATCH, 28'd2, '0, 1'b0, 1'b1);
      // only position-neutral ops: empty whole-span block
      send_op(OP_INS, LEN_MAX, START_MAX, 1'b1, 1'b0);
      send_op(OP_SOFT, 28'd7, '0, 1'b0, 1'b0);
      send_op(OP_HARD, '0, '0, 1'b0, 1'b0);
      send_op(OP_PAD, LEN_MAX, '0, 1'b0, 1'b1);
      // empty close, then saturation, then a closing last op
      send_op(OP_SKIP, '0, START_MAX, 1'b1, 1'b0);
      send_op(OP_DEL, LEN_MAX, '0, 1'b0, 1'b0);
      repeat (8) send_op(OP_MATCH, LEN_MAX, '0, 1'b0, 1'b0);
      send_op(OP_SKIP, LEN_MAX, '0, 1'b0, 1'b1);
      // invalid op: rest ignored, bad end marker
      send_op(OP_MATCH, 28'd4, 31'd10, 1'b1, 1'b0);
      send_op(OP_BAD_LOW, '0, '0, 1'b0, 1'b0);
      send_op(OP_MATCH, 28'd3, '0, 1'b0, 1'b0);
      send_op(OP_BAD_HIGH, '0, '0, 1'b0, 1'b1);
      // blocks emitted, open block empty at the end: plain end marker
      send_op(OP_MATCH, 28'd20, '0, 1'b1, 1'b0);
      send_op(OP_SKIP, 28'd1, '0, 1'b0, 1'b0);
      send_op(OP_SKIP, 28'd2, '0, 1'b0, 1'b1);

      write_break(1'b1);
      send_op(OP_MATCH, 28'd3, 31'd5, 1'b1, 1'b0);
      send_op(OP_DEL, 28'd2, '0, 1'b0, 1'b0);
      send_op(OP_DEL, '0, '0, 1'b0, 1'b0);
      send_op(OP_MATCH, 28'd1, '0, 1'b0, 1'b0);
      send_op(OP_DEL, 28'd4, '0, 1'b0, 1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         write_break(phase[0]);
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 51; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 51; end
            default: begin idle_pct = 32; stall_pct = 32; end
         endcase
         random_ops(PHASE_ITEMS);
      end

      drain();
      repeat (20) @(negedge clock);
      if (sb.pending() != 0) $error("%0d expected blocks never arrived", sb.pending());
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

>>> sim.f
hdl/cbs_pkg.sv
hdl/cbs_front.sv
hdl/cbs_queue.sv
hdl/cbs_back.sv
hdl/cigar_block_splitter.sv
hdl/cbs_checker.sv
tb/tb_top.sv
